[sv/cobs_frame_receiver_xor_check_core_defines.svh]
// Assertion macros shared by the receiver modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef COBS_FRAME_RECEIVER_XOR_CHECK_CORE_DEFINES_SVH
`define COBS_FRAME_RECEIVER_XOR_CHECK_CORE_DEFINES_SVH
`ifndef SYNTH
`define CFRX_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");
`define CFRX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequence check violated");
`else
`define CFRX_ASSERT_ALWAYS(label, expr)
`define CFRX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/cfrx_pkg.sv]
package cfrx_pkg;

	localparam int MAX_FRAME_DEFAULT = 128;

	localparam logic [7:0] BLOCK_CODE_FULL = 8'hff;

	localparam logic [1:0] KIND_TYPE    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	localparam logic [2:0] ST_GOOD      = 3'd0;
	localparam logic [2:0] ST_CHECKSUM  = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_SHORT     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [2:0] status;
		logic [7:0] payload_length;
	} result_t;

endpackage

[sv/cfrx_out_skid.sv]
`include "cobs_frame_receiver_xor_check_core_defines.svh"

// Output register with one skid entry, so the decoder keeps accepting while
// the downstream side stalls, until the skid entry fills.
module cfrx_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cfrx_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output cfrx_pkg::result_t out_data
);

	logic              out_valid_q;
	cfrx_pkg::result_t out_data_q;
	logic              skid_valid_q;
	cfrx_pkg::result_t skid_data_q;
	logic              out_load;

	assign out_load  = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	`CFRX_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_q || out_valid_q)
	`CFRX_ASSERT_ALWAYS(a_no_push_when_full, !(push && skid_valid_q))
	`CFRX_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall, out_valid_q && !skid_valid_q)

endmodule

[sv/cobs_frame_receiver_xor_check_core.sv]
// A result reaches out_valid through the output register, or through the skid entry.
// Throughput: one byte per cycle while in_stall is low; decode is a single registered pass.
// A one-entry skid behind the output register keeps input going in a stall until it fills.
// Reset (arst_n low, asynchronous) clears the frame state to idle and empties the output.
// The first beat after reset is the start of a new frame.
`include "cobs_frame_receiver_xor_check_core_defines.svh"

module cobs_frame_receiver_xor_check_core #(
	parameter int MAX_FRAME = cfrx_pkg::MAX_FRAME_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic [2:0] status,
	output logic [7:0] payload_length
);

	localparam logic [7:0] MaxCount = 8'(MAX_FRAME);

	// Frame state. Every field is control state and is cleared by reset.
	logic [7:0] frame_byte_count_q;
	logic [7:0] block_remaining_q;
	logic       previous_code_full_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;
	logic [7:0] running_xor_q;
	logic [7:0] emitted_count_q;
	logic       malformed_flag_q;
	logic       overflow_flag_q;

	logic [7:0] frame_byte_count_d;
	logic [7:0] block_remaining_d;
	logic       previous_code_full_d;
	logic       held_valid_d;
	logic [7:0] held_byte_d;
	logic [7:0] running_xor_d;
	logic [7:0] emitted_count_d;
	logic       malformed_flag_d;
	logic       overflow_flag_d;

	logic              accept;
	logic              res_valid;
	cfrx_pkg::result_t res;
	logic              skid_full;
	cfrx_pkg::result_t out_data;

	logic       do_push;
	logic [7:0] push_byte;

	assign accept   = in_valid && !in_stall;
	assign in_stall = skid_full;

	// One decode step for the byte at the input. A zero byte closes the frame
	// with a frame-end beat; a nonzero byte is dropped past the frame limit, else
	// it is a block code or a data byte. Each decoded byte replaces the held one,
	// and the held one leaves, so the last decoded byte stays behind as the checksum.
	always_comb begin
		frame_byte_count_d   = frame_byte_count_q;
		block_remaining_d    = block_remaining_q;
		previous_code_full_d = previous_code_full_q;
		held_valid_d         = held_valid_q;
		held_byte_d          = held_byte_q;
		running_xor_d        = running_xor_q;
		emitted_count_d      = emitted_count_q;
		malformed_flag_d     = malformed_flag_q;
		overflow_flag_d      = overflow_flag_q;
		res_valid            = 1'b0;
		res                  = '0;
		do_push              = 1'b0;
		push_byte            = 8'd0;

		if (rx_byte == 8'd0) begin
			// Delimiter: report and return to the idle frame state.
			res_valid = 1'b1;
			res.kind  = cfrx_pkg::KIND_END;
			res.payload_length = (emitted_count_q != 8'd0) ? emitted_count_q - 8'd1 : 8'd0;
			if (overflow_flag_q) begin
				res.status = cfrx_pkg::ST_OVERFLOW;
			end else if (malformed_flag_q || block_remaining_q != 8'd0) begin
				res.status = cfrx_pkg::ST_MALFORMED;
			end else if (emitted_count_q == 8'd0) begin
				res.status = cfrx_pkg::ST_SHORT;
			end else if (running_xor_q != held_byte_q) begin
				res.status = cfrx_pkg::ST_CHECKSUM;
			end else begin
				res.status = cfrx_pkg::ST_GOOD;
			end
			frame_byte_count_d   = 8'd0;
			block_remaining_d    = 8'd0;
			previous_code_full_d = 1'b1;
			held_valid_d         = 1'b0;
			held_byte_d          = 8'd0;
			running_xor_d        = 8'd0;
			emitted_count_d      = 8'd0;
			malformed_flag_d     = 1'b0;
			overflow_flag_d      = 1'b0;
		end else if (frame_byte_count_q >= MaxCount) begin
			// Frame too long: the byte is dropped and the frame marked.
			overflow_flag_d = 1'b1;
		end else begin
			frame_byte_count_d = frame_byte_count_q + 8'd1;
			if (block_remaining_q == 8'd0) begin
				// Block code. A code after a short block stands for a zero byte.
				do_push              = !previous_code_full_q;
				push_byte            = 8'd0;
				previous_code_full_d = (rx_byte == cfrx_pkg::BLOCK_CODE_FULL);
				if (rx_byte == cfrx_pkg::BLOCK_CODE_FULL) begin
					malformed_flag_d = 1'b1;
				end
				block_remaining_d = rx_byte - 8'd1;
			end else begin
				block_remaining_d = block_remaining_q - 8'd1;
				do_push           = 1'b1;
				push_byte         = rx_byte;
			end
		end

		if (do_push) begin
			if (held_valid_q) begin
				res_valid = 1'b1;
				res.kind  = (emitted_count_q == 8'd0) ? cfrx_pkg::KIND_TYPE
				                                      : cfrx_pkg::KIND_PAYLOAD;
				res.value     = held_byte_q;
				running_xor_d = running_xor_q ^ held_byte_q;
				if (emitted_count_q != 8'hff) begin
					emitted_count_d = emitted_count_q + 8'd1;
				end
			end
			held_byte_d  = push_byte;
			held_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_byte_count_q   <= 8'd0;
			block_remaining_q    <= 8'd0;
			previous_code_full_q <= 1'b1;
			held_valid_q         <= 1'b0;
			held_byte_q          <= 8'd0;
			running_xor_q        <= 8'd0;
			emitted_count_q      <= 8'd0;
			malformed_flag_q     <= 1'b0;
			overflow_flag_q      <= 1'b0;
		end else if (accept) begin
			frame_byte_count_q   <= frame_byte_count_d;
			block_remaining_q    <= block_remaining_d;
			previous_code_full_q <= previous_code_full_d;
			held_valid_q         <= held_valid_d;
			held_byte_q          <= held_byte_d;
			running_xor_q        <= running_xor_d;
			emitted_count_q      <= emitted_count_d;
			malformed_flag_q     <= malformed_flag_d;
			overflow_flag_q      <= overflow_flag_d;
		end
	end

	// The output register and its skid entry decouple the two sides.
	cfrx_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind           = out_data.kind;
	assign value          = out_data.value;
	assign status         = out_data.status;
	assign payload_length = out_data.payload_length;

	// A byte is emitted only after a later one has been held in its place.
	`CFRX_ASSERT_ALWAYS(a_emit_implies_held, emitted_count_q == 8'd0 || held_valid_q)
	// The encoded byte count never passes the frame limit.
	`CFRX_ASSERT_ALWAYS(a_count_bounded, frame_byte_count_q <= MaxCount)
	// Overflow is only flagged once the frame has filled up.
	`CFRX_ASSERT_ALWAYS(a_overflow_full, !overflow_flag_q || frame_byte_count_q == MaxCount)

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// The receiver is built with its default maximum frame size. The model below
	// keeps its own copy of that bound.
	localparam int FRAME_LIMIT = cfrx_pkg::MAX_FRAME_DEFAULT;

	// Stimulus stops after the frame in which this many received bytes are accepted.
	localparam int RX_BYTE_TARGET = 1700;

	// The slowest correct run is roughly 1700 bytes, each with the longest input gap
	// and the longest output stall. This limit is several times that run.
	localparam int CYCLE_LIMIT = 200000;

	// A few extra cycles after the last expected result catch any stray beat.
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] octets_t[$];

	// Frame decoder model and store of expected output beats. It follows the
	// receiver byte by byte. Each decoded byte is held back by one decoded byte,
	// so the last one of a frame is compared against the running XOR as the
	// checksum and is never emitted.
	class frame_scoreboard;
		logic [7:0]        enc_count;
		logic [7:0]        block_left;
		logic [7:0]        held_byte;
		logic [7:0]        xor_acc;
		logic [7:0]        emitted;
		bit                last_code_full;
		bit                held_ok;
		bit                bad_code;
		bit                overflowed;
		cfrx_pkg::result_t expected_q[$];
		int                errors;

		function new();
			clear_frame();
			errors = 0;
		endfunction

		function void clear_frame();
			enc_count = '0;
			block_left = '0;
			held_byte = '0;
			xor_acc = '0;
			emitted = '0;
			last_code_full = 1'b1;
			held_ok = 1'b0;
			bad_code = 1'b0;
			overflowed = 1'b0;
		endfunction

		// A new decoded byte pushes the held one out as a type or payload beat.
		function void release_decoded(logic [7:0] d);
			cfrx_pkg::result_t beat;
			if (held_ok) begin
				beat = '0;
				beat.kind = (emitted == 0) ? cfrx_pkg::KIND_TYPE
				                           : cfrx_pkg::KIND_PAYLOAD;
				beat.value = held_byte;
				expected_q.push_back(beat);
				xor_acc ^= held_byte;
				if (emitted != 8'hff)
					emitted++;
			end
			held_byte = d;
			held_ok = 1'b1;
		endfunction

		function void take_rx_byte(logic [7:0] b);
			cfrx_pkg::result_t fin;
			if (b == 8'h00) begin
				fin = '0;
				fin.kind = cfrx_pkg::KIND_END;
				fin.payload_length = (emitted != 0) ? emitted - 8'd1 : 8'd0;
				if (overflowed)
					fin.status = cfrx_pkg::ST_OVERFLOW;
				else if (bad_code || block_left != 0)
					fin.status = cfrx_pkg::ST_MALFORMED;
				else if (emitted == 0)
					fin.status = cfrx_pkg::ST_SHORT;
				else if (xor_acc != held_byte)
					fin.status = cfrx_pkg::ST_CHECKSUM;
				else
					fin.status = cfrx_pkg::ST_GOOD;
				expected_q.push_back(fin);
				clear_frame();
				return;
			end
			if (enc_count >= FRAME_LIMIT) begin
				overflowed = 1'b1;
				return;
			end
			enc_count++;
			if (block_left == 0) begin
				// Code byte. A short block before it implies a zero data byte.
				if (!last_code_full)
					release_decoded(8'h00);
				last_code_full = (b == cfrx_pkg::BLOCK_CODE_FULL);
				if (b == cfrx_pkg::BLOCK_CODE_FULL)
					bad_code = 1'b1;
				block_left = b - 8'd1;
			end else begin
				block_left--;
				release_decoded(b);
			end
		endfunction

		function void check_result(cfrx_pkg::result_t got);
			cfrx_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: beat with none expected: kind %0d value %02h status %0d",
					$time, got.kind, got.value, got.status);
				$display("%0t: beat with none expected: length %0d",
					$time, got.payload_length);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
				errors++;
			end
			if (got.value !== want.value) begin
				$display("%0t: value expected %02h actual %02h", $time, want.value, got.value);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.payload_length !== want.payload_length) begin
				$display("%0t: payload_length expected %0d actual %0d", $time,
					want.payload_length, got.payload_length);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] value;
	logic [2:0] status;
	logic [7:0] payload_length;

	frame_scoreboard sb;

	// When set, neither side idles for the current frame, so the receiver runs at
	// full rate for a stretch.
	bit calm = 1'b0;
	int rx_sent = 0;
	int unsigned cycle_count = 0;

	cobs_frame_receiver_xor_check_core #(
		.MAX_FRAME(FRAME_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.status(status),
		.payload_length(payload_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog. A hang or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int idle_draw();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// Decoded data for random frames. Zeros are common so that short COBS blocks
	// and implied zero bytes come up often.
	function automatic logic [7:0] rand_octet();
		return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
	endfunction

	// Builds the decoded content of a frame: type byte, payload and a trailing
	// XOR checksum. The checksum is spoiled on request.
	function automatic void make_frame(input int n_bytes, input bit good_sum,
			output octets_t raw);
		logic [7:0] sum;
		logic [7:0] d;
		sum = '0;
		raw = {};
		repeat (n_bytes) begin
			d = rand_octet();
			raw.push_back(d);
			sum ^= d;
		end
		raw.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
	endfunction

	// Plain COBS encoding without the delimiter. A run of 254 nonzero bytes
	// produces a full block code, which this receiver flags as malformed.
	function automatic void cobs_encode(input octets_t raw, output octets_t enc);
		int         code_at;
		logic [7:0] code;
		enc = {};
		code_at = 0;
		enc.push_back(8'h00);
		code = 8'd1;
		foreach (raw[i]) begin
			if (raw[i] == 8'h00) begin
				enc[code_at] = code;
				code_at = enc.size();
				enc.push_back(8'h00);
				code = 8'd1;
			end else begin
				enc.push_back(raw[i]);
				code++;
				if (code == cfrx_pkg::BLOCK_CODE_FULL) begin
					enc[code_at] = code;
					code_at = enc.size();
					enc.push_back(8'h00);
					code = 8'd1;
				end
			end
		end
		enc[code_at] = code;
	endfunction

	// Sends one received byte. The valid stays high into the next beat when no
	// gap is drawn, so a back-to-back stream never drops valid.
	task automatic send_rx(input logic [7:0] b);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.take_rx_byte(b);
		rx_sent++;
	endtask

	// One random frame, delimiter included. Most frames are well formed with
	// random content so that the decoder gets deep into its states. The rest are
	// broken checksums, noise, truncated frames, very short frames, frames near or
	// past the size limit, and frames that open with a full block code.
	task automatic send_random_frame();
		octets_t raw;
		octets_t enc;
		int      pick;
		int      cut;
		calm = ($urandom_range(0, 7) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			make_frame($urandom_range(1, 24), 1'b1, raw);
			cobs_encode(raw, enc);
		end else if (pick < 70) begin
			make_frame($urandom_range(1, 24), 1'b0, raw);
			cobs_encode(raw, enc);
		end else if (pick < 78) begin
			enc = {};
			repeat ($urandom_range(1, 20))
				enc.push_back(8'($urandom_range(1, 255)));
		end else if (pick < 85) begin
			// A good frame cut off early. It often ends inside a block.
			make_frame($urandom_range(1, 24), 1'b1, raw);
			cobs_encode(raw, enc);
			cut = $urandom_range(0, enc.size() - 1);
			while (enc.size() > cut)
				void'(enc.pop_back());
		end else if (pick < 90) begin
			case ($urandom_range(0, 2))
				0: enc = {};
				1: enc = {8'h01};
				default: enc = {8'h02, 8'($urandom_range(1, 255))};
			endcase
		end else if (pick < 96) begin
			// Sizes straddle the frame limit. Frames past it must report overflow.
			make_frame($urandom_range(110, 200), 1'b1, raw);
			cobs_encode(raw, enc);
		end else begin
			enc = {cfrx_pkg::BLOCK_CODE_FULL};
			repeat ($urandom_range(0, 30))
				enc.push_back(8'($urandom_range(1, 255)));
		end
		foreach (enc[i])
			send_rx(enc[i]);
		send_rx(8'h00);
	endtask

	// Input side. The directed frames come first: an empty frame right after
	// reset, a frame of one empty block, a minimal good frame, a frame with
	// implied zeros and a bad checksum, a full block code, and a delimiter
	// that arrives inside a block.
	initial begin
		octets_t directed;
		sb = new();
		directed = {8'h00,
			8'h01, 8'h00,
			8'h03, 8'h41, 8'h41, 8'h00,
			8'h02, 8'h7f, 8'h02, 8'h80, 8'h01, 8'h00,
			8'h02, 8'h11, 8'hff, 8'h22, 8'h00,
			8'h04, 8'h12, 8'h00};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_rx(directed[i]);
		while (rx_sent < RX_BYTE_TARGET)
			send_random_frame();
		in_valid <= 1'b0;

		// Every frame ends with a delimiter, and so with a result. Once the store
		// is empty, a short wait catches any extra beat.
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Output side. Before each beat it stalls for a random number of cycles. The
	// stall can fall while no result is pending as well, which exercises the skid.
	initial begin
		int                hold;
		cfrx_pkg::result_t got;
		wait (arst_n === 1'b1);
		forever begin
			hold = idle_draw();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
			got.kind = kind;
			got.value = value;
			got.status = status;
			got.payload_length = payload_length;
			sb.check_result(got);
		end
	end

endmodule
